/* design/lpmr_pkg.sv */
// Package for the length-prefixed message ring: word types, codes and states.
package lpmr_pkg;

  localparam int unsigned BUF_BYTES_DEF = 4096;

  localparam logic [2:0] MODE_START_WR = 3'd0;
  localparam logic [2:0] MODE_WR_BYTE  = 3'd1;
  localparam logic [2:0] MODE_START_RD = 3'd2;
  localparam logic [2:0] MODE_PEEK     = 3'd3;
  localparam logic [2:0] MODE_RD_BYTE  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_SMALL   = 3'd3;
  localparam logic [2:0] ST_SEQ     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_RH,
    S_RL,
    S_RB
  } state_e;

  typedef enum logic [1:0] {
    K_IDLE,
    K_CONSUME,
    K_PEEK
  } kind_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data;
    logic [14:0] msg_length;
    logic [15:0] reader_capacity;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_res;
    logic [14:0] msg_length_res;
    logic        last;
    logic [12:0] stored_messages;
    logic [12:0] free_bytes;
  } out_word_t;

endpackage

/* design/length_prefixed_message_ring.sv */
// Length-prefixed message ring: byte ring of framed messages in one memory.
//
// One input channel (in_valid_i / in_stall_o / in_word_i) takes command words;
// one output channel (out_valid_o / out_stall_i / out_word_o) returns exactly
// one result word per command, in order. A word moves when valid is high and
// stall is low.
// Each message sits in the ring as a two-byte big-endian length header and its
// payload; addresses wrap modulo BUF_BYTES. The ring is one memory with one
// write and one read port, read data registered.
// States per command: write byte and any refused command stay in S_IDLE; an
//   accepted start write passes S_HDR (second header byte write), read byte
//   S_RB (memory read data registered), start read or peek past the sequence
//   and empty checks S_RH and S_RL (two header reads through the one read
//   port). Results of start write, write byte and refused commands appear the
//   cycle after accept; the others load from the read data in S_RL or S_RB.
// A command is taken while a previous result still waits, as long as that
// result leaves the output register in the same cycle. A stalled receiver
// holds the result and, once the register is full, stalls the input.
// Reset empties the ring (all counters and pointers cleared, free bytes set to
// BUF_BYTES); no clearing pass, the memory content is left as it was.
module length_prefixed_message_ring #(
  parameter int unsigned BUF_BYTES = lpmr_pkg::BUF_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpmr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpmr_pkg::out_word_t out_word_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam int unsigned CW = $clog2(BUF_BYTES + 1);
  localparam int unsigned SW = ((CW > 16) ? CW : 16) + 1;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + {{(AW-1){1'b0}}, n};
    if (s >= (AW+1)'(BUF_BYTES)) begin
      s = s - (AW+1)'(BUF_BYTES);
    end
    return s[AW-1:0];
  endfunction

  lpmr_pkg::state_e state_q, state_d;
  lpmr_pkg::kind_e  kind_q, kind_d;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
  logic [AW-1:0] hdr_addr_q, hdr_addr_d;
  logic [CW-1:0] free_q, free_d, msgs_q, msgs_d;
  logic [14:0]   wrem_q, wrem_d, rrem_q, rrem_d, olen_q, olen_d;
  logic [7:0]    hdr_lo_q, hdr_lo_d, hdr_hi_q, hdr_hi_d;
  logic [15:0]   cap_q, cap_d;
  logic          peek_q, peek_d, last_pend_q, last_pend_d;

  logic                out_valid_q, out_valid_d;
  lpmr_pkg::out_word_t out_q, out_d;
  logic                out_load;

  logic [7:0]    mem_q [BUF_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic          accept, go_hdr, go_rh, go_rb;
  logic [14:0]   hdr_len;
  logic [SW-1:0] need, free_sum;

  assign in_stall_o  = !((state_q == lpmr_pkg::S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign hdr_len     = {hdr_hi_q[6:0], rdata_q};
  assign need        = SW'(in_word_i.msg_length) + SW'(2);
  assign free_sum    = SW'(free_q) + SW'(olen_q) + SW'(2);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpmr_pkg::S_IDLE: begin
        if (go_hdr) begin
          state_d = lpmr_pkg::S_HDR;
        end else if (go_rh) begin
          state_d = lpmr_pkg::S_RH;
        end else if (go_rb) begin
          state_d = lpmr_pkg::S_RB;
        end
      end
      lpmr_pkg::S_HDR: state_d = lpmr_pkg::S_IDLE;
      lpmr_pkg::S_RH:  state_d = lpmr_pkg::S_RL;
      lpmr_pkg::S_RL:  state_d = lpmr_pkg::S_IDLE;
      lpmr_pkg::S_RB:  state_d = lpmr_pkg::S_IDLE;
      default:         state_d = lpmr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cursor_d    = cursor_q;
    hdr_addr_d  = hdr_addr_q;
    free_d      = free_q;
    msgs_d      = msgs_q;
    wrem_d      = wrem_q;
    rrem_d      = rrem_q;
    olen_d      = olen_q;
    hdr_lo_d    = hdr_lo_q;
    hdr_hi_d    = hdr_hi_q;
    cap_d       = cap_q;
    peek_d      = peek_q;
    last_pend_d = last_pend_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = in_word_i.data;
    mem_re      = 1'b0;
    mem_raddr   = head_q;
    go_hdr      = 1'b0;
    go_rh       = 1'b0;
    go_rb       = 1'b0;
    out_load    = 1'b0;
    out_d       = '0;
    out_d.status = lpmr_pkg::ST_SEQ;

    case (state_q)
      lpmr_pkg::S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (in_word_i.mode)
            lpmr_pkg::MODE_START_WR: begin
              if (wrem_q != '0) begin
                out_d.status = lpmr_pkg::ST_SEQ;
              end else if (in_word_i.msg_length == '0 || need > SW'(free_q)) begin
                out_d.status = lpmr_pkg::ST_NOSPACE;
              end else begin
                mem_we       = 1'b1;
                mem_wdata    = {1'b0, in_word_i.msg_length[14:8]};
                hdr_lo_d     = in_word_i.msg_length[7:0];
                hdr_addr_d   = wrap_add(tail_q, 2'd1);
                tail_d       = wrap_add(tail_q, 2'd2);
                free_d       = CW'(SW'(free_q) - need);
                wrem_d       = in_word_i.msg_length;
                go_hdr       = 1'b1;
                out_d.status = lpmr_pkg::ST_OK;
              end
            end
            lpmr_pkg::MODE_WR_BYTE: begin
              if (wrem_q != '0) begin
                mem_we       = 1'b1;
                tail_d       = wrap_add(tail_q, 2'd1);
                wrem_d       = wrem_q - 15'd1;
                out_d.status = lpmr_pkg::ST_OK;
                if (wrem_q == 15'd1) begin
                  out_d.last = 1'b1;
                  msgs_d     = msgs_q + CW'(1);
                end
              end
            end
            lpmr_pkg::MODE_START_RD, lpmr_pkg::MODE_PEEK: begin
              if (kind_q != lpmr_pkg::K_IDLE) begin
                out_d.status = lpmr_pkg::ST_SEQ;
              end else if (msgs_q == '0) begin
                out_d.status = lpmr_pkg::ST_EMPTY;
              end else begin
                out_load  = 1'b0;
                mem_re    = 1'b1;
                mem_raddr = head_q;
                cap_d     = in_word_i.reader_capacity;
                peek_d    = (in_word_i.mode == lpmr_pkg::MODE_PEEK);
                go_rh     = 1'b1;
              end
            end
            lpmr_pkg::MODE_RD_BYTE: begin
              if (kind_q != lpmr_pkg::K_IDLE && rrem_q != '0) begin
                out_load    = 1'b0;
                mem_re      = 1'b1;
                mem_raddr   = cursor_q;
                cursor_d    = wrap_add(cursor_q, 2'd1);
                rrem_d      = rrem_q - 15'd1;
                last_pend_d = (rrem_q == 15'd1);
                go_rb       = 1'b1;
                if (rrem_q == 15'd1) begin
                  kind_d = lpmr_pkg::K_IDLE;
                  if (kind_q == lpmr_pkg::K_CONSUME) begin
                    head_d = wrap_add(cursor_q, 2'd1);
                    if (msgs_q != '0) begin
                      msgs_d = msgs_q - CW'(1);
                    end
                    if (free_sum > SW'(BUF_BYTES)) begin
                      free_d = CW'(BUF_BYTES);
                    end else begin
                      free_d = CW'(free_sum);
                    end
                  end
                end
              end
            end
            default: out_d.status = lpmr_pkg::ST_SEQ;
          endcase
        end
      end
      lpmr_pkg::S_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_addr_q;
        mem_wdata = hdr_lo_q;
      end
      lpmr_pkg::S_RH: begin
        hdr_hi_d  = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_q, 2'd1);
      end
      lpmr_pkg::S_RL: begin
        out_load = 1'b1;
        if (cap_q < {1'b0, hdr_len}) begin
          out_d.status = lpmr_pkg::ST_SMALL;
        end else begin
          rrem_d               = hdr_len;
          olen_d               = hdr_len;
          cursor_d             = wrap_add(head_q, 2'd2);
          kind_d               = peek_q ? lpmr_pkg::K_PEEK : lpmr_pkg::K_CONSUME;
          out_d.status         = lpmr_pkg::ST_OK;
          out_d.msg_length_res = hdr_len;
        end
      end
      lpmr_pkg::S_RB: begin
        out_load       = 1'b1;
        out_d.status   = lpmr_pkg::ST_OK;
        out_d.data_res = rdata_q;
        out_d.last     = last_pend_q;
      end
      default: ;
    endcase

    out_d.stored_messages = 13'(msgs_d);
    out_d.free_bytes      = 13'(free_d);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpmr_pkg::S_IDLE;
      kind_q      <= lpmr_pkg::K_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cursor_q    <= '0;
      free_q      <= CW'(BUF_BYTES);
      msgs_q      <= '0;
      wrem_q      <= '0;
      rrem_q      <= '0;
      olen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cursor_q    <= cursor_d;
      free_q      <= free_d;
      msgs_q      <= msgs_d;
      wrem_q      <= wrem_d;
      rrem_q      <= rrem_d;
      olen_q      <= olen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_addr_q  <= hdr_addr_d;
    hdr_lo_q    <= hdr_lo_d;
    hdr_hi_q    <= hdr_hi_d;
    cap_q       <= cap_d;
    peek_q      <= peek_d;
    last_pend_q <= last_pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CW'(BUF_BYTES))
    else $error("free count above ring size");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lpmr_pkg::S_IDLE) |-> in_stall_o)
    else $error("input taken while a command is in progress");

  a_hdr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpmr_pkg::S_RH) |=> (state_q == lpmr_pkg::S_RL))
    else $error("header read sequence broken");

  a_deferred_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpmr_pkg::S_RB || state_q == lpmr_pkg::S_RL) |=> out_valid_o)
    else $error("read result not delivered to output register");

endmodule

/* dv/lpmr_scoreboard.sv */
// Scoreboard for the message ring: predicts each result word and compares it field by field.
`timescale 1ns / 100ps

module lpmr_scoreboard #(
  parameter int unsigned BUF_BYTES = lpmr_pkg::BUF_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lpmr_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lpmr_pkg::out_word_t out_word_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic [7:0]  ring_bytes [BUF_BYTES];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned free_cnt;
  int unsigned msg_cnt;
  int unsigned wr_left;
  int unsigned rd_left;
  int unsigned rd_ptr;
  int unsigned rd_len;
  lpmr_pkg::kind_e rd_kind;

  lpmr_pkg::out_word_t replies_due [$];
  lpmr_pkg::out_word_t due;
  int          mismatches = 0;

  assign errors_o = mismatches;

  function automatic lpmr_pkg::out_word_t ring_reply(lpmr_pkg::in_word_t w);
    lpmr_pkg::out_word_t r;
    int unsigned len;
    logic [15:0] hdr;
    r = '0;
    r.status = lpmr_pkg::ST_SEQ;
    len = w.msg_length;
    case (w.mode)
      lpmr_pkg::MODE_START_WR: begin
        if (wr_left == 0) begin
          if (len == 0 || len + 2 > free_cnt) begin
            r.status = lpmr_pkg::ST_NOSPACE;
          end else begin
            ring_bytes[tail_ptr] = 8'(len >> 8);
            ring_bytes[(tail_ptr + 1) % BUF_BYTES] = 8'(len);
            tail_ptr = (tail_ptr + 2) % BUF_BYTES;
            free_cnt -= len + 2;
            wr_left = len;
            r.status = lpmr_pkg::ST_OK;
          end
        end
      end
      lpmr_pkg::MODE_WR_BYTE: begin
        if (wr_left != 0) begin
          ring_bytes[tail_ptr] = w.data;
          tail_ptr = (tail_ptr + 1) % BUF_BYTES;
          wr_left--;
          if (wr_left == 0) begin
            r.last = 1'b1;
            msg_cnt++;
          end
          r.status = lpmr_pkg::ST_OK;
        end
      end
      lpmr_pkg::MODE_START_RD, lpmr_pkg::MODE_PEEK: begin
        if (rd_kind == lpmr_pkg::K_IDLE) begin
          if (msg_cnt == 0) begin
            r.status = lpmr_pkg::ST_EMPTY;
          end else begin
            hdr = {ring_bytes[head_ptr], ring_bytes[(head_ptr + 1) % BUF_BYTES]};
            len = hdr[14:0];
            if (w.reader_capacity < len) begin
              r.status = lpmr_pkg::ST_SMALL;
            end else begin
              rd_left = len;
              rd_len = len;
              rd_ptr = (head_ptr + 2) % BUF_BYTES;
              rd_kind = (w.mode == lpmr_pkg::MODE_START_RD) ? lpmr_pkg::K_CONSUME
                                                            : lpmr_pkg::K_PEEK;
              r.msg_length_res = 15'(len);
              r.status = lpmr_pkg::ST_OK;
            end
          end
        end
      end
      lpmr_pkg::MODE_RD_BYTE: begin
        if (rd_kind != lpmr_pkg::K_IDLE && rd_left != 0) begin
          r.data_res = ring_bytes[rd_ptr];
          rd_ptr = (rd_ptr + 1) % BUF_BYTES;
          rd_left--;
          if (rd_left == 0) begin
            r.last = 1'b1;
            if (rd_kind == lpmr_pkg::K_CONSUME) begin
              head_ptr = rd_ptr;
              if (msg_cnt != 0) msg_cnt--;
              free_cnt += rd_len + 2;
              if (free_cnt > BUF_BYTES) free_cnt = BUF_BYTES;
            end
            rd_kind = lpmr_pkg::K_IDLE;
          end
          r.status = lpmr_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.stored_messages = 13'(msg_cnt);
    r.free_bytes = 13'(free_cnt);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr = 0;
      tail_ptr = 0;
      free_cnt = BUF_BYTES;
      msg_cnt = 0;
      wr_left = 0;
      rd_left = 0;
      rd_ptr = 0;
      rd_len = 0;
      rd_kind = lpmr_pkg::K_IDLE;
      replies_due.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result word with none outstanding: expected none, got %h",
                   $time, out_word_i);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          check_field("status", due.status, out_word_i.status);
          check_field("data_res", due.data_res, out_word_i.data_res);
          check_field("msg_length_res", due.msg_length_res, out_word_i.msg_length_res);
          check_field("last", due.last, out_word_i.last);
          check_field("stored_messages", due.stored_messages, out_word_i.stored_messages);
          check_field("free_bytes", due.free_bytes, out_word_i.free_bytes);
        end
      end
      if (in_valid_i && !in_stall_i) replies_due.push_back(ring_reply(in_word_i));
      pending_o = replies_due.size();
    end
  end

endmodule

/* dv/length_prefixed_message_ring_test.sv */
// Testbench top for the message ring: clock, reset, command stimulus, receiver and verdict.
`timescale 1ns / 100ps

module length_prefixed_message_ring_test;

  localparam int unsigned RING_BYTES = lpmr_pkg::BUF_BYTES_DEF;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lpmr_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  lpmr_pkg::out_word_t out_word;
  int        mismatches;
  int        outstanding;
  int        sent = 0;

  // stimulus-side view of the ring, used only to steer command choice
  int unsigned trk_free = RING_BYTES;
  int unsigned trk_wr_left = 0;
  int unsigned trk_wr_len = 0;
  int unsigned trk_rd_left = 0;
  lpmr_pkg::kind_e trk_rd_kind = lpmr_pkg::K_IDLE;
  int unsigned trk_lens [$];

  always #1 clk = ~clk;

  length_prefixed_message_ring #(.BUF_BYTES(RING_BYTES)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  lpmr_scoreboard #(.BUF_BYTES(RING_BYTES)) u_score (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .errors_o    (mismatches),
    .pending_o   (outstanding)
  );

  function automatic lpmr_pkg::in_word_t mk(logic [2:0] m, logic [7:0] d, logic [14:0] l,
                                            logic [15:0] c);
    lpmr_pkg::in_word_t w;
    w.mode = m;
    w.data = d;
    w.msg_length = l;
    w.reader_capacity = c;
    return w;
  endfunction

  function automatic void track_word(lpmr_pkg::in_word_t w);
    case (w.mode)
      lpmr_pkg::MODE_START_WR: begin
        if (trk_wr_left == 0 && w.msg_length != 0 &&
            int'(w.msg_length) + 2 <= int'(trk_free)) begin
          trk_free -= w.msg_length + 2;
          trk_wr_left = w.msg_length;
          trk_wr_len = w.msg_length;
        end
      end
      lpmr_pkg::MODE_WR_BYTE: begin
        if (trk_wr_left != 0) begin
          trk_wr_left--;
          if (trk_wr_left == 0) trk_lens.push_back(trk_wr_len);
        end
      end
      lpmr_pkg::MODE_START_RD, lpmr_pkg::MODE_PEEK: begin
        if (trk_rd_kind == lpmr_pkg::K_IDLE && trk_lens.size() != 0 &&
            w.reader_capacity >= trk_lens[0]) begin
          trk_rd_kind = (w.mode == lpmr_pkg::MODE_START_RD) ? lpmr_pkg::K_CONSUME
                                                            : lpmr_pkg::K_PEEK;
          trk_rd_left = trk_lens[0];
        end
      end
      lpmr_pkg::MODE_RD_BYTE: begin
        if (trk_rd_kind != lpmr_pkg::K_IDLE && trk_rd_left != 0) begin
          trk_rd_left--;
          if (trk_rd_left == 0) begin
            if (trk_rd_kind == lpmr_pkg::K_CONSUME) begin
              trk_free += trk_lens[0] + 2;
              void'(trk_lens.pop_front());
            end
            trk_rd_kind = lpmr_pkg::K_IDLE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(lpmr_pkg::in_word_t w);
    int pct;
    pct = (sent >= 300 && sent < 600) ? 0 : 14;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    track_word(w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_head(logic [2:0] rd_mode);
    int unsigned n;
    n = trk_lens[0];
    send_word(mk(rd_mode, 8'h00, 15'h0000, 16'(n)));
    repeat (n) begin
      send_word(mk(lpmr_pkg::MODE_RD_BYTE, 8'($urandom_range(0, 255)), 15'h0000,
                   16'h0000));
    end
  endtask

  initial begin : receiver
    int cyc;
    cyc = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 600 && cyc < 900) begin
        out_stall <= 1'b1;
      end else if (cyc >= 1200 && cyc < 1800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 14);
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("** length_prefixed_message_ring: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned len;
    int unsigned cap;
    int          made;
    in_valid = 1'b0;
    in_word = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: sequence errors, empty ring, bad lengths, invisible open write,
    // too-small reader, peek then consume, write interleaved with a read
    send_word(mk(lpmr_pkg::MODE_RD_BYTE, 8'h00, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_PEEK, 8'h00, 15'h0000, 16'hFFFF));
    send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'hFF, 15'h0000, 16'h0000));
    for (int m = lpmr_pkg::MODE_RD_BYTE + 1; m < 8; m++) begin
      send_word(mk(3'(m), 8'hFF, 15'h7FFF, 16'hFFFF));
    end
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'd0, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'h7FFF, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'(RING_BYTES - 1), 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'd3, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'd5, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_RD, 8'h00, 15'h0000, 16'hFFFF));
    send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'h00, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'hFF, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'hA5, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_PEEK, 8'h00, 15'h0000, 16'd2));
    send_word(mk(lpmr_pkg::MODE_PEEK, 8'h00, 15'h0000, 16'd3));
    send_word(mk(lpmr_pkg::MODE_START_RD, 8'h00, 15'h0000, 16'hFFFF));
    repeat (4) send_word(mk(lpmr_pkg::MODE_RD_BYTE, 8'h00, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_START_RD, 8'h00, 15'h0000, 16'd3));
    send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'd1, 16'h0000));
    repeat (3) send_word(mk(lpmr_pkg::MODE_RD_BYTE, 8'h00, 15'h0000, 16'h0000));
    send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'h5A, 15'h0000, 16'h0000));
    drain_head(lpmr_pkg::MODE_START_RD);

    made = 0;
    while (made < 1100) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(mk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     15'($urandom_range(RING_BYTES, 32767)), 16'($urandom)));
      end else begin
        made++;
        if (trk_wr_left != 0 && r < 55) begin
          send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'($urandom_range(0, 255)), 15'h0000,
                       16'h0000));
        end else if (trk_rd_kind != lpmr_pkg::K_IDLE && r < 90) begin
          send_word(mk(lpmr_pkg::MODE_RD_BYTE, 8'($urandom_range(0, 255)), 15'h0000,
                       16'h0000));
        end else if (trk_rd_kind == lpmr_pkg::K_IDLE && trk_lens.size() != 0 && r < 75) begin
          len = trk_lens[0];
          case ($urandom_range(0, 9))
            0:       cap = len - 1;
            1, 2:    cap = len;
            default: cap = $urandom_range(len, 65535);
          endcase
          send_word(mk($urandom_range(0, 1) ? lpmr_pkg::MODE_START_RD : lpmr_pkg::MODE_PEEK,
                       8'h00, 15'h0000, 16'(cap)));
        end else if (trk_wr_left == 0) begin
          case ($urandom_range(0, 39))
            0:       len = 0;
            1, 2:    len = $urandom_range(256, 600);
            3:       len = (trk_free <= 600) ? trk_free - 2 + $urandom_range(0, 2) : 30;
            default: len = $urandom_range(1, 40);
          endcase
          send_word(mk(lpmr_pkg::MODE_START_WR, 8'h00, 15'(len), 16'h0000));
        end else begin
          send_word(mk(lpmr_pkg::MODE_WR_BYTE, 8'($urandom_range(0, 255)), 15'h0000,
                       16'h0000));
        end
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("** length_prefixed_message_ring: PASSED **");
    end else begin
      $display("** length_prefixed_message_ring: FAILED **");
    end
    $finish;
  end

endmodule
